[src/tsf_pkg.sv]
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, widths and helpers of the triangle scanline fill unit: item
// structs, vertex and crossing request types, register codes, crop rounding.
// ----------------------------------------------------------------------------
package tsf_pkg;

    // Field widths of the input and result items
    localparam int COORD_BITS = 12;
    localparam int ROW_BITS   = 6;
    localparam int COL_BITS   = 8;
    localparam int CHAR_BITS  = 8;

    // Configuration register widths and reset values
    localparam int CFG_W_BITS = 9;
    localparam int CFG_H_BITS = 7;
    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 9'd80;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 7'd32;

    // APB port geometry
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // Arithmetic widths of the crossing unit
    localparam int SX_BITS   = COORD_BITS + 2;              // x scaled by 4
    localparam int XW        = SX_BITS + 2;                 // crossing / difference
    localparam int DY_BITS   = COORD_BITS + 1;              // y differences
    localparam int PROD_BITS = XW + DY_BITS;                // signed product
    localparam int MAG_BITS  = PROD_BITS - 1;               // product magnitude
    localparam int DEN_BITS  = COORD_BITS;                  // divisor magnitude
    localparam int DIV_STEPS = (MAG_BITS + 1) / 2;          // two bits per cycle
    localparam int DIV_BITS  = 2 * DIV_STEPS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    // Crop rounding bias
    localparam logic signed [XW:0] CROP_BIAS = (XW+1)'(2);

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] third_x;
        logic signed [COORD_BITS-1:0] third_y;
        logic        [CHAR_BITS-1:0]  fill_char;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  span_start;
        logic [COL_BITS-1:0]  span_end;
        logic                 span_empty;
        logic [CHAR_BITS-1:0] char_out;
        logic                 last_row;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vertex_t;

    // One edge crossing: start point, end point and the row
    typedef struct packed {
        logic signed [SX_BITS-1:0]    xs;
        logic signed [COORD_BITS-1:0] ys;
        logic signed [SX_BITS-1:0]    xe;
        logic signed [COORD_BITS-1:0] ye;
        logic        [ROW_BITS-1:0]   y;
    } cross_req_t;

    // Signed divide by four, truncating toward zero
    function automatic logic signed [XW:0] div4_trunc(input logic signed [XW:0] v);
        logic signed [XW:0] q;
        q = v >>> 2;
        if (v[XW] && (v[1:0] != 2'b00))
        begin
            q = q + (XW+1)'(1);
        end
        return q;
    endfunction

endpackage

[src/tsf_sort.sv]
// ----------------------------------------------------------------------------
// tsf_sort
// Stable three-vertex sort by y with strict compares (bubble order).
// ----------------------------------------------------------------------------
module tsf_sort
    import tsf_pkg::*;
(
    input  in_item_t item,
    output vertex_t  sorted [3]
);

    vertex_t a0;
    vertex_t a1;
    vertex_t a2;
    vertex_t t;

    // Swap first/second, second/third, then first/second again
    always_comb
    begin
        a0 = '{x: item.first_x,  y: item.first_y};
        a1 = '{x: item.second_x, y: item.second_y};
        a2 = '{x: item.third_x,  y: item.third_y};
        t  = a0;
        if (a0.y > a1.y)
        begin
            t  = a0;
            a0 = a1;
            a1 = t;
        end
        if (a1.y > a2.y)
        begin
            t  = a1;
            a1 = a2;
            a2 = t;
        end
        if (a0.y > a1.y)
        begin
            t  = a0;
            a0 = a1;
            a1 = t;
        end
        sorted[0] = a0;
        sorted[1] = a1;
        sorted[2] = a2;
    end

endmodule

[src/tsf_cross.sv]
// ----------------------------------------------------------------------------
// tsf_cross
// Shared edge crossing unit: xs + (xe-xs)*(y-ys)/(ye-ys), truncating toward
// zero. A multiply state, then a restoring divider retiring two bits per
// cycle on magnitudes. A horizontal edge returns xe.
// ----------------------------------------------------------------------------
module tsf_cross
    import tsf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  cross_req_t               req,
    output logic                     done,
    output logic signed [XW-1:0]     result
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_MUL  = 4'b0010,
        C_DIV  = 4'b0100,
        C_DONE = 4'b1000
    } cross_state_t;

    cross_state_t state_reg, state_next;

    logic signed [SX_BITS-1:0]   xs_reg;
    logic signed [SX_BITS-1:0]   xe_reg;
    logic signed [XW-1:0]        dx_reg;
    logic signed [DY_BITS-1:0]   dyn_reg;
    logic signed [DY_BITS-1:0]   den_reg;
    logic                        neg_reg;
    logic                        horiz_reg;
    logic [DEN_BITS-1:0]         dmag_reg;
    logic [DEN_BITS-1:0]         rem_reg;
    logic [DIV_BITS-1:0]         quo_reg;
    logic [STEP_BITS-1:0]        cnt_reg;

    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] pmag;
    logic signed [DY_BITS-1:0]   dmag;
    logic [DEN_BITS:0]           r1;
    logic [DEN_BITS:0]           r1s;
    logic                        ge1;
    logic [DIV_BITS-1:0]         q1;
    logic [DEN_BITS:0]           r2;
    logic [DEN_BITS:0]           r2s;
    logic                        ge2;
    logic [DIV_BITS-1:0]         q2;
    logic signed [XW-1:0]        qv;

    // Multiply the differences, take magnitudes
    assign prod = PROD_BITS'(dx_reg) * PROD_BITS'(dyn_reg);
    assign pmag = prod[PROD_BITS-1] ? -prod : prod;
    assign dmag = den_reg[DY_BITS-1] ? -den_reg : den_reg;

    // Two restoring steps per cycle
    always_comb
    begin
        r1  = {rem_reg, quo_reg[DIV_BITS-1]};
        ge1 = (r1 >= {1'b0, dmag_reg});
        r1s = ge1 ? (r1 - {1'b0, dmag_reg}) : r1;
        q1  = {quo_reg[DIV_BITS-2:0], ge1};
        r2  = {r1s[DEN_BITS-1:0], q1[DIV_BITS-1]};
        ge2 = (r2 >= {1'b0, dmag_reg});
        r2s = ge2 ? (r2 - {1'b0, dmag_reg}) : r2;
        q2  = {q1[DIV_BITS-2:0], ge2};
    end

    // Apply the sign and add the start point
    assign qv     = $signed({1'b0, quo_reg[XW-2:0]});
    assign result = horiz_reg ? XW'(xe_reg) : (XW'(xs_reg) + (neg_reg ? -qv : qv));
    assign done   = (state_reg == C_DONE);

    // Sequence the unit
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                state_next = (den_reg == '0) ? C_DONE : C_DIV;
            end
            C_DIV:
            begin
                if (cnt_reg == STEP_BITS'(DIV_STEPS - 1))
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == C_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == C_DIV)
            begin
                cnt_reg <= cnt_reg + STEP_BITS'(1);
            end
        end
    end

    // Capture operands, load the divider, advance it
    always_ff @(posedge clk)
    begin
        if ((state_reg == C_IDLE) && start)
        begin
            xs_reg  <= req.xs;
            xe_reg  <= req.xe;
            dx_reg  <= XW'(req.xe) - XW'(req.xs);
            dyn_reg <= DY_BITS'($signed({1'b0, req.y})) - DY_BITS'(req.ys);
            den_reg <= DY_BITS'(req.ye) - DY_BITS'(req.ys);
        end
        else if (state_reg == C_MUL)
        begin
            horiz_reg <= (den_reg == '0);
            neg_reg   <= prod[PROD_BITS-1] ^ den_reg[DY_BITS-1];
            dmag_reg  <= dmag[DEN_BITS-1:0];
            quo_reg   <= DIV_BITS'(pmag[MAG_BITS-1:0]);
            rem_reg   <= '0;
        end
        else if (state_reg == C_DIV)
        begin
            rem_reg <= r2s[DEN_BITS-1:0];
            quo_reg <= q2;
        end
    end

endmodule

[src/triangle_scanline_fill_unit.sv]
// Sequence: the setup state after a transfer, then for each row both edge crossings
// on the shared multiply/divide unit (a horizontal edge skips the divide) and an
// emit state that loads the row into the result register.
// Throughput: one triangle at a time; input stalls until the last row is loaded,
// longer while the result side stalls.
// Reset: rst_n clears the sequencer and output valid, width to 80, height to 32.
// ----------------------------------------------------------------------------
// triangle_scanline_fill_unit
// Sorts the vertices by y, walks the visible rows, computes both edge
// crossings per row on one shared unit, crops and clips the span.
// ----------------------------------------------------------------------------
module triangle_scanline_fill_unit
    import tsf_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam logic signed [XW:0]      COL_CAP = (XW+1)'(MAX_COLS);
    localparam logic signed [DY_BITS-1:0] ROW_CAP = DY_BITS'(MAX_ROWS);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_START   = 7'b0000010,
        S_CROSS_A = 7'b0000100,
        S_WAIT_A  = 7'b0001000,
        S_CROSS_B = 7'b0010000,
        S_WAIT_B  = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W_BITS-1:0]       width_reg;
    logic [CFG_H_BITS-1:0]       height_reg;
    vertex_t                     sorted [3];
    vertex_t                     vert_reg [3];
    logic [CHAR_BITS-1:0]        char_reg;
    logic [ROW_BITS-1:0]         y_reg;
    logic [ROW_BITS-1:0]         ylast_reg;
    logic signed [XW-1:0]        xa_reg;
    logic signed [XW-1:0]        xb_reg;
    logic                        out_valid_reg;
    out_item_t                   out_data_reg;

    logic                        in_take;
    logic                        cfg_write;
    logic                        emit_load;
    logic                        is_last;
    logic signed [DY_BITS-1:0]   hext;
    logic signed [DY_BITS-1:0]   ylim;
    logic signed [XW:0]          wext;
    logic signed [XW:0]          xmax;
    logic signed [DY_BITS-1:0]   vy0;
    logic signed [DY_BITS-1:0]   vy2;
    logic signed [DY_BITS-1:0]   y0;
    logic signed [DY_BITS-1:0]   ylast;
    logic                        upper;
    logic signed [SX_BITS-1:0]   sx0;
    logic signed [SX_BITS-1:0]   sx1;
    logic signed [SX_BITS-1:0]   sx2;
    cross_req_t                  req_a;
    cross_req_t                  req_b;
    cross_req_t                  req;
    logic                        cross_start;
    logic                        cross_done;
    logic signed [XW-1:0]        cross_x;
    logic signed [XW:0]          lo;
    logic signed [XW:0]          hi;
    logic signed [XW:0]          ra;
    logic signed [XW:0]          rb;
    logic signed [XW:0]          cs;
    logic signed [XW:0]          ce;
    logic                        empty;
    out_item_t                   span;

    // Register file: write on the access phase, read back by address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(paddr[2]))
                REG_WIDTH:  width_reg  <= pwdata[CFG_W_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_H_BITS-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_WIDTH:  prdata = DATA_BITS'(width_reg);
            REG_HEIGHT: prdata = DATA_BITS'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // Screen limits: clamp to the configured maximum, last row and column
    assign hext = $signed(DY_BITS'(height_reg));
    assign ylim = ((hext > ROW_CAP) ? ROW_CAP : hext) - DY_BITS'(1);
    assign wext = $signed((XW+1)'(width_reg));
    assign xmax = ((wext > COL_CAP) ? COL_CAP : wext) - (XW+1)'(1);

    // Sort the incoming vertices
    tsf_sort u_sort (
        .item   (in_data),
        .sorted (sorted)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    // Visible row range
    assign vy0   = DY_BITS'(vert_reg[0].y);
    assign vy2   = DY_BITS'(vert_reg[2].y);
    assign y0    = vy0[DY_BITS-1] ? '0 : vy0;
    assign ylast = (vy2 < ylim) ? vy2 : ylim;

    // Edge selection for the current row
    assign sx0   = $signed({vert_reg[0].x, 2'b00});
    assign sx1   = $signed({vert_reg[1].x, 2'b00});
    assign sx2   = $signed({vert_reg[2].x, 2'b00});
    assign upper = DY_BITS'($signed({1'b0, y_reg})) <= DY_BITS'(vert_reg[1].y);

    always_comb
    begin
        if (upper)
        begin
            req_a = '{xs: sx0, ys: vert_reg[0].y, xe: sx1, ye: vert_reg[1].y, y: y_reg};
            req_b = '{xs: sx0, ys: vert_reg[0].y, xe: sx2, ye: vert_reg[2].y, y: y_reg};
        end
        else
        begin
            req_a = '{xs: sx2, ys: vert_reg[2].y, xe: sx1, ye: vert_reg[1].y, y: y_reg};
            req_b = '{xs: sx2, ys: vert_reg[2].y, xe: sx0, ye: vert_reg[0].y, y: y_reg};
        end
        req = (state_reg == S_CROSS_B) ? req_b : req_a;
    end

    assign cross_start = (state_reg == S_CROSS_A) || (state_reg == S_CROSS_B);

    tsf_cross u_cross (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cross_start),
        .req    (req),
        .done   (cross_done),
        .result (cross_x)
    );

    // Order the crossings, crop-round, clip to the screen
    always_comb
    begin
        lo    = (xb_reg < xa_reg) ? (XW+1)'(xb_reg) : (XW+1)'(xa_reg);
        hi    = (xb_reg < xa_reg) ? (XW+1)'(xa_reg) : (XW+1)'(xb_reg);
        ra    = div4_trunc(lo + CROP_BIAS);
        rb    = div4_trunc(hi - CROP_BIAS);
        cs    = ra[XW] ? '0 : ra;
        ce    = (rb > xmax) ? xmax : rb;
        empty = rb[XW] || (ra > xmax) || (cs > ce);
        is_last = (y_reg == ylast_reg);
        span.row        = y_reg;
        span.span_start = empty ? '0 : cs[COL_BITS-1:0];
        span.span_end   = empty ? '0 : ce[COL_BITS-1:0];
        span.span_empty = empty;
        span.char_out   = char_reg;
        span.last_row   = is_last;
    end

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // Row sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (y0 > ylast) ? S_IDLE : S_CROSS_A;
            end
            S_CROSS_A:
            begin
                state_next = S_WAIT_A;
            end
            S_WAIT_A:
            begin
                if (cross_done)
                begin
                    state_next = S_CROSS_B;
                end
            end
            S_CROSS_B:
            begin
                state_next = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (cross_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = is_last ? S_IDLE : S_CROSS_A;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the triangle, step rows, hold crossings and the result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            vert_reg[0] <= sorted[0];
            vert_reg[1] <= sorted[1];
            vert_reg[2] <= sorted[2];
            char_reg    <= in_data.fill_char;
        end
        if (state_reg == S_START)
        begin
            y_reg     <= y0[ROW_BITS-1:0];
            ylast_reg <= ylast[ROW_BITS-1:0];
        end
        else if (emit_load)
        begin
            y_reg <= y_reg + ROW_BITS'(1);
        end
        if ((state_reg == S_WAIT_A) && cross_done)
        begin
            xa_reg <= cross_x;
        end
        if ((state_reg == S_WAIT_B) && cross_done)
        begin
            xb_reg <= cross_x;
        end
        if (emit_load)
        begin
            out_data_reg <= span;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/tsf_checker.sv]
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks of the triangle scanline fill unit, bound to the top.
// ----------------------------------------------------------------------------
module tsf_checker
    import tsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data
);

    // Hold a stalled result
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed or dropped");

    // Stall input in the setup state after each transfer
    property p_busy_after_take;
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall;
    endproperty
    a_busy_after_take: assert property (p_busy_after_take)
        else $error("input accepted while a triangle is in progress");

    // Drive zero columns on an empty span
    property p_empty_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_data.span_empty |->
            (out_data.span_start == '0) && (out_data.span_end == '0);
    endproperty
    a_empty_zero: assert property (p_empty_zero)
        else $error("empty span carries nonzero columns");

    // Keep a drawn span ordered
    property p_span_order;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.span_empty |-> out_data.span_start <= out_data.span_end;
    endproperty
    a_span_order: assert property (p_span_order)
        else $error("drawn span has start past end");

endmodule

bind triangle_scanline_fill_unit tsf_checker u_tsf_checker (.*);

[bench/tsf_span_checker.sv]
// ----------------------------------------------------------------------------
// tsf_span_checker
// Watches the configuration port and both item channels of the triangle
// scanline fill unit, predicts the span results of every accepted triangle
// and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tsf_span_checker
    import tsf_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  out_item_t            out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output int unsigned          pending,
    output int unsigned          fails
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W_BITS-1:0] cols_q;
    logic [CFG_H_BITS-1:0] rows_q;
    out_item_t             span_q[$];
    out_item_t             want;

    // Column where the edge from (xs,ys) to (xe,ye) crosses row y, x scaled by 4
    function automatic longint crossing_x(input longint xs, input longint ys,
                                          input longint xe, input longint ye,
                                          input longint y);
        if (ys == ye)
        begin
            return xe;
        end
        return xs + (xe - xs) * (y - ys) / (ye - ys);
    endfunction

    // Queue the spans of one triangle, top row first
    function automatic void plan_spans(input in_item_t shape);
        longint    vx[3];
        longint    vy[3];
        longint    tmp, xmax, ylim, ytop, ybot, xa, xb, y;
        int        k;
        bit        swapped;
        out_item_t s;
        vx[0] = $signed(shape.first_x);
        vy[0] = $signed(shape.first_y);
        vx[1] = $signed(shape.second_x);
        vy[1] = $signed(shape.second_y);
        vx[2] = $signed(shape.third_x);
        vy[2] = $signed(shape.third_y);
        // stable bubble sort by y, restarting after each swap
        do
        begin
            swapped = 1'b0;
            for (k = 0; k < 2; k++)
            begin
                if (!swapped && vy[k] > vy[k+1])
                begin
                    tmp = vy[k]; vy[k] = vy[k+1]; vy[k+1] = tmp;
                    tmp = vx[k]; vx[k] = vx[k+1]; vx[k+1] = tmp;
                    swapped = 1'b1;
                end
            end
        end
        while (swapped);
        for (k = 0; k < 3; k++)
        begin
            vx[k] = vx[k] * 4;
        end
        // clip limits, oversized screens saturate at the maximum
        xmax = longint'(cols_q);
        if (xmax > MAX_COLS)
        begin
            xmax = MAX_COLS;
        end
        xmax = xmax - 1;
        ylim = longint'(rows_q);
        if (ylim > MAX_ROWS)
        begin
            ylim = MAX_ROWS;
        end
        ylim = ylim - 1;
        ytop = (vy[0] < 0) ? 0 : vy[0];
        ybot = (vy[2] < ylim) ? vy[2] : ylim;
        for (y = ytop; y <= ybot; y++)
        begin
            if (y <= vy[1])
            begin
                xa = crossing_x(vx[0], vy[0], vx[1], vy[1], y);
                xb = crossing_x(vx[0], vy[0], vx[2], vy[2], y);
            end
            else
            begin
                xa = crossing_x(vx[2], vy[2], vx[1], vy[1], y);
                xb = crossing_x(vx[2], vy[2], vx[0], vy[0], y);
            end
            if (xb < xa)
            begin
                tmp = xa; xa = xb; xb = tmp;
            end
            // crop rounding back to character columns
            xa = (xa + 2) / 4;
            xb = (xb - 2) / 4;
            s = '0;
            s.row = y[ROW_BITS-1:0];
            s.char_out = shape.fill_char;
            s.last_row = (y == ybot);
            if (xb < 0 || xa > xmax)
            begin
                s.span_empty = 1'b1;
            end
            else
            begin
                if (xa < 0)
                begin
                    xa = 0;
                end
                if (xb > xmax)
                begin
                    xb = xmax;
                end
                if (xa > xb)
                begin
                    s.span_empty = 1'b1;
                end
                else
                begin
                    s.span_start = xa[COL_BITS-1:0];
                    s.span_end = xb[COL_BITS-1:0];
                end
            end
            span_q.push_back(s);
        end
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    // Track register writes, compare result transfers, predict input transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_q = WIDTH_RESET;
            rows_q = HEIGHT_RESET;
            span_q.delete();
            fails = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[ADDR_BITS-1:2]))
                    REG_WIDTH:  cols_q = pwdata[CFG_W_BITS-1:0];
                    REG_HEIGHT: rows_q = pwdata[CFG_H_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (span_q.size() == 0)
                begin
                    $error("span result for row %0d with no triangle outstanding",
                           out_data.row);
                    fails++;
                end
                else
                begin
                    want = span_q.pop_front();
                    check_field("row", want.row, out_data.row);
                    check_field("span_start", want.span_start, out_data.span_start);
                    check_field("span_end", want.span_end, out_data.span_end);
                    check_field("span_empty", want.span_empty, out_data.span_empty);
                    check_field("char_out", want.char_out, out_data.char_out);
                    check_field("last_row", want.last_row, out_data.last_row);
                end
            end
            if (in_valid && !in_stall)
            begin
                plan_spans(in_data);
            end
            pending <= span_q.size();
        end
    end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives triangles and screen sizes into the triangle scanline fill unit:
// a directed set of corner shapes at reset size, then random triangles over
// several screen sizes, with random idling on both channels outside the calm phase.
// ----------------------------------------------------------------------------
module testbench
    import tsf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 256;
    localparam int DRAIN_CYCLES = 100;
    localparam int RUN_LIMIT_NS = 60_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 calm = 1'b0;
    int unsigned          pending;
    int unsigned          fails;

    triangle_scanline_fill_unit #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    tsf_span_checker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) i_span_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pending   (pending),
        .fails     (fails)
    );

    always #10 clk = ~clk;

    // Stall the result side at random, except in a calm phase
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 20);
    end

    function automatic in_item_t mk(input int ax, input int ay, input int bx,
                                    input int by, input int cx, input int cy,
                                    input int c);
        in_item_t t;
        t.first_x = COORD_BITS'(ax);
        t.first_y = COORD_BITS'(ay);
        t.second_x = COORD_BITS'(bx);
        t.second_y = COORD_BITS'(by);
        t.third_x = COORD_BITS'(cx);
        t.third_y = COORD_BITS'(cy);
        t.fill_char = CHAR_BITS'(c);
        return t;
    endfunction

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Mostly shapes near the screen, some wide ones, some raw noise
    function automatic in_item_t random_shape(input int cols, input int rows);
        int mode;
        int reach;
        mode = $urandom_range(99);
        if (mode < 15)
        begin
            return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
        end
        reach = (mode < 30) ? 400 : 0;
        return mk(pick(-16 - reach, cols + 16 + reach), pick(-4 - reach, rows + 4 + reach),
                  pick(-16 - reach, cols + 16 + reach), pick(-4 - reach, rows + 4 + reach),
                  pick(-16 - reach, cols + 16 + reach), pick(-4 - reach, rows + 4 + reach),
                  $urandom_range(255));
    endfunction

    // One triangle transfer, with an optional idle gap in front
    task automatic send_shape(input in_item_t shape);
        if (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= shape;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Hold the input until every expected span has come, then let the unit settle
    task automatic drain_spans();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input cfg_reg_t which, input logic [DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Set the screen size, send random triangles, pause once midway, drain
    task automatic run_phase(input int w, input int h, input int count, input bit quiet);
        int cols;
        int rows;
        int k;
        calm <= quiet;
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        cols = (w == 0) ? 8 : ((w > MAX_COLS) ? MAX_COLS : w);
        rows = (h == 0) ? 8 : ((h > MAX_ROWS) ? MAX_ROWS : h);
        for (k = 0; k < count; k++)
        begin
            if (k == count / 2)
            begin
                drain_spans();
            end
            send_shape(random_shape(cols, rows));
        end
        drain_spans();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner shapes at the reset size of 80 by 32
        send_shape(mk(0, 0, 79, 0, 0, 31, 8'h41));
        send_shape(mk(10, 20, 40, 5, 70, 20, 8'h2A));
        send_shape(mk(5, 10, 50, 10, 30, 10, 8'h00));
        send_shape(mk(30, 30, 10, 2, 60, 15, 8'hFF));
        send_shape(mk(-2048, -2048, 2047, 2047, -2048, 2047, 8'h55));
        send_shape(mk(2047, -2048, -2048, 2047, 2047, 2047, 8'hAA));
        send_shape(mk(-2048, 2047, 2047, -2048, 0, 0, 8'h01));
        send_shape(mk(0, -30, 40, -10, 79, -1, 8'h11));
        send_shape(mk(0, 32, 40, 100, 79, 40, 8'h12));
        send_shape(mk(-100, 0, -50, 10, -80, 20, 8'h13));
        send_shape(mk(200, 0, 300, 10, 100, 20, 8'h14));
        send_shape(mk(10, 0, 10, 20, 11, 10, 8'h15));
        send_shape(mk(40, 8, 20, 8, 30, 2, 8'h16));
        send_shape(mk(-500, -1000, 600, 1500, 40, 16, 8'h17));
        send_shape(mk(40, 16, 40, 16, 40, 16, 8'h18));
        send_shape(mk(79, 0, 79, 31, 78, 15, 8'h19));
        send_shape(mk(0, 31, 79, 31, 40, 31, 8'h1A));
        send_shape(mk(-1, -1, -1, -1, -1, -1, 8'hFF));
        drain_spans();

        // random triangles over a spread of screen sizes, extremes included
        run_phase(256, 64, 40, 1'b0);
        run_phase(1, 1, 25, 1'b0);
        run_phase(511, 127, 30, 1'b1);
        run_phase(0, 20, 15, 1'b0);
        run_phase(100, 0, 8, 1'b0);
        repeat (4)
        begin
            run_phase($urandom_range(1, 511), $urandom_range(1, 127), 20, 1'b0);
        end

        if (fails == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #RUN_LIMIT_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
